FILE: rtl/midpoint_circle_rasterizer_assert.svh
// assertion macros used by the rasterizer emitter module
`ifndef MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define MCR_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define MCR_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("next-cycle check failed");
`else
`define MCR_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define MCR_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

FILE: rtl/mcr_pkg.sv
`default_nettype none

package mcr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 10;
  localparam int DEC_BITS    = RADIUS_BITS + 6;
  localparam int OUT_BITS    = COORD_BITS + 1;
  // octant x and y carry a sign so that y can drop below zero at the end
  localparam int OCT_BITS    = RADIUS_BITS + 1;
  localparam int SUM_BITS    = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

  localparam int PIX_PER_STEP = 8;
  localparam int IDX_BITS     = 3;
  localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(PIX_PER_STEP - 1);

  // decision constants of the midpoint scheme
  localparam logic signed [DEC_BITS-1:0] DEC_INIT     = DEC_BITS'(3);
  localparam logic signed [DEC_BITS-1:0] DEC_ADD_INC  = DEC_BITS'(6);
  localparam logic signed [DEC_BITS-1:0] DEC_ADD_DIAG = DEC_BITS'(10);

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_t;

  // one step's worth of pixel data, handed from the stepper to the emitter
  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [OCT_BITS-1:0]   x;
    logic signed [OCT_BITS-1:0]   y;
    logic                         done;
  } snap_t;

  typedef struct packed {
    logic swap;
    logic neg_x;
    logic neg_y;
  } octant_t;

  // symmetry of pixel k within a step
  function automatic octant_t octant_sel(input logic [IDX_BITS-1:0] k);
    octant_t o;
    o.swap  = 1'b0;
    o.neg_x = 1'b0;
    o.neg_y = 1'b0;
    case (k) inside
      3'd1, 3'd3, 3'd5, 3'd6: o.swap = 1'b1;
      default: o.swap = 1'b0;
    endcase
    case (k) inside
      [3'd2:3'd5]: o.neg_x = 1'b1;
      default: o.neg_x = 1'b0;
    endcase
    case (k) inside
      [3'd4:3'd7]: o.neg_y = 1'b1;
      default: o.neg_y = 1'b0;
    endcase
    return o;
  endfunction

  // center plus or minus an octant offset, wrapped to the pixel width
  function automatic logic signed [OUT_BITS-1:0] pix_add(
    input logic signed [COORD_BITS-1:0] c,
    input logic signed [OCT_BITS-1:0]   a,
    input logic                         neg
  );
    logic signed [SUM_BITS-1:0] ce;
    logic signed [SUM_BITS-1:0] ae;
    logic signed [SUM_BITS-1:0] s;
    ce = {{(SUM_BITS - COORD_BITS){c[COORD_BITS-1]}}, c};
    ae = {{(SUM_BITS - OCT_BITS){a[OCT_BITS-1]}}, a};
    s  = neg ? (ce - ae) : (ce + ae);
    return s[OUT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mcr_step.sv
`default_nettype none

module mcr_step (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   accept,
  input  wire logic                                   func,
  input  wire logic signed [mcr_pkg::COORD_BITS-1:0]  center_x,
  input  wire logic signed [mcr_pkg::COORD_BITS-1:0]  center_y,
  input  wire logic        [mcr_pkg::RADIUS_BITS-1:0] radius,
  output logic                                        load,
  output mcr_pkg::snap_t                              snap
);

  logic signed [mcr_pkg::OCT_BITS-1:0]   octant_x;
  logic signed [mcr_pkg::OCT_BITS-1:0]   octant_y;
  logic signed [mcr_pkg::DEC_BITS-1:0]   decision;
  logic signed [mcr_pkg::COORD_BITS-1:0] held_center_x;
  logic signed [mcr_pkg::COORD_BITS-1:0] held_center_y;
  logic                                  circle_active;

  logic signed [mcr_pkg::OCT_BITS-1:0] octant_x_next;
  logic signed [mcr_pkg::OCT_BITS-1:0] octant_y_next;
  logic signed [mcr_pkg::DEC_BITS-1:0] decision_next;
  logic signed [mcr_pkg::DEC_BITS-1:0] decision_init;
  logic signed [mcr_pkg::DEC_BITS-1:0] x_ext;
  logic signed [mcr_pkg::DEC_BITS-1:0] y_ext;
  logic signed [mcr_pkg::DEC_BITS-1:0] r_ext;
  logic                                done_next;
  logic                                is_step;

  assign is_step = (func == mcr_pkg::FUNC_STEP);

  // decision and octant update for one step
  always_comb begin
    x_ext = {{(mcr_pkg::DEC_BITS - mcr_pkg::OCT_BITS){octant_x[mcr_pkg::OCT_BITS-1]}},
             octant_x};
    y_ext = {{(mcr_pkg::DEC_BITS - mcr_pkg::OCT_BITS){octant_y[mcr_pkg::OCT_BITS-1]}},
             octant_y};
    r_ext = {{(mcr_pkg::DEC_BITS - mcr_pkg::RADIUS_BITS){1'b0}}, radius};
    decision_init = mcr_pkg::DEC_INIT - (r_ext <<< 1);
    octant_x_next = octant_x + mcr_pkg::OCT_BITS'(1);
    if (decision[mcr_pkg::DEC_BITS-1]) begin
      decision_next = decision + (x_ext <<< 2) + mcr_pkg::DEC_ADD_INC;
      octant_y_next = octant_y;
    end else begin
      decision_next = decision + ((x_ext - y_ext) <<< 2) + mcr_pkg::DEC_ADD_DIAG;
      octant_y_next = octant_y - mcr_pkg::OCT_BITS'(1);
    end
    done_next = (octant_x_next > octant_y_next);
  end

  // snapshot of the current point for the emitter
  assign load      = accept && is_step && circle_active;
  assign snap.cx   = held_center_x;
  assign snap.cy   = held_center_y;
  assign snap.x    = octant_x;
  assign snap.y    = octant_y;
  assign snap.done = done_next;

  // circle state
  always_ff @(posedge clk) begin
    if (rst) begin
      octant_x      <= '0;
      octant_y      <= '0;
      decision      <= '0;
      held_center_x <= '0;
      held_center_y <= '0;
      circle_active <= 1'b0;
    end else if (accept && !is_step) begin
      held_center_x <= center_x;
      held_center_y <= center_y;
      octant_x      <= '0;
      octant_y      <= {1'b0, radius};
      decision      <= decision_init;
      circle_active <= 1'b1;
    end else if (load) begin
      octant_x      <= octant_x_next;
      octant_y      <= octant_y_next;
      decision      <= decision_next;
      circle_active <= !done_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mcr_emit.sv
`default_nettype none

`include "midpoint_circle_rasterizer_assert.svh"

module mcr_emit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 load,
  input  wire mcr_pkg::snap_t                       snap_in,
  output logic                                      free,
  output logic                                      pix_valid,
  input  wire logic                                 pix_stall,
  output logic signed [mcr_pkg::OUT_BITS-1:0]       pixel_x,
  output logic signed [mcr_pkg::OUT_BITS-1:0]       pixel_y,
  output logic                                      step_last,
  output logic                                      circle_done
);

  logic                          busy;
  logic [mcr_pkg::IDX_BITS-1:0]  idx;
  mcr_pkg::snap_t                held;

  logic                          pop;
  mcr_pkg::octant_t              oct;
  logic signed [mcr_pkg::OCT_BITS-1:0] a_x;
  logic signed [mcr_pkg::OCT_BITS-1:0] a_y;

  assign pix_valid = busy;
  assign pop       = busy && !pix_stall;
  assign step_last = (idx == mcr_pkg::IDX_LAST);
  assign free      = !busy || (pop && step_last);

  // pixel k of the held step
  always_comb begin
    oct         = mcr_pkg::octant_sel(idx);
    a_x         = oct.swap ? held.y : held.x;
    a_y         = oct.swap ? held.x : held.y;
    pixel_x     = mcr_pkg::pix_add(held.cx, a_x, oct.neg_x);
    pixel_y     = mcr_pkg::pix_add(held.cy, a_y, oct.neg_y);
    circle_done = step_last && held.done;
  end

  // step buffer and pixel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (pop) begin
      idx <= idx + mcr_pkg::IDX_BITS'(1);
      if (step_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= snap_in;
    end
  end

  `MCR_ASSERT_NEXT(a_load_starts, clk, rst, load, busy && idx == '0)
  `MCR_ASSERT_NEXT(a_last_frees, clk, rst, pop && step_last && !load, !busy)
  `MCR_ASSERT_IMPLIES(a_load_when_free, clk, rst, load, free)
  `MCR_ASSERT_IMPLIES(a_idle_index, clk, rst, !busy, idx == '0)

endmodule

`default_nettype wire

FILE: rtl/midpoint_circle_rasterizer.sv
`default_nettype none

// Midpoint circle rasterizer. A start request (func = 0) loads center and radius and
// produces no pixel; a step request while no circle is active has no effect,
// though like any step it waits while the buffer still holds pixels. A step request on
// an active circle yields eight pixels, one per cycle while pix_stall is low, on the pixel
// port starting the cycle after the step is taken, with step_last on the eighth and
// circle_done on the eighth pixel of the final step. The step buffer holds one step, and
// the next step request is taken in the cycle its predecessor's eighth pixel is taken, so
// a stream of steps is paced by the single pixel output port. Start requests are never
// stalled while the buffer drains, since the buffer keeps its own copy of the center.
module midpoint_circle_rasterizer (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cmd_valid,
  output logic                                        cmd_stall,
  input  wire logic                                   func,
  input  wire logic signed [mcr_pkg::COORD_BITS-1:0]  center_x,
  input  wire logic signed [mcr_pkg::COORD_BITS-1:0]  center_y,
  input  wire logic        [mcr_pkg::RADIUS_BITS-1:0] radius,
  output logic                                        pix_valid,
  input  wire logic                                   pix_stall,
  output logic signed [mcr_pkg::OUT_BITS-1:0]         pixel_x,
  output logic signed [mcr_pkg::OUT_BITS-1:0]         pixel_y,
  output logic                                        step_last,
  output logic                                        circle_done
);

  logic           accept;
  logic           load;
  logic           free;
  mcr_pkg::snap_t snap;

  // hold step requests while a buffered step still has pixels to go
  assign cmd_stall = !free && (func == mcr_pkg::FUNC_STEP);
  assign accept    = cmd_valid && !cmd_stall;

  mcr_step u_step (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .func     (func),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .load     (load),
    .snap     (snap)
  );

  mcr_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .snap_in     (snap),
    .free        (free),
    .pix_valid   (pix_valid),
    .pix_stall   (pix_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .step_last   (step_last),
    .circle_done (circle_done)
  );

endmodule

`default_nettype wire
